>>> hw/rtl/lmsd_pkg.sv
`timescale 1ns / 1ps
// lmsd_pkg: shared types, sizes and a helper function of the led matrix scan driver
// no dependencies

package lmsd_pkg;

    localparam int LED_COUNT    = 24;
    localparam int PIN_COUNT    = 30;
    localparam int BUTTON_COUNT = 128;

    localparam int MAP_LEDS     = 24;
    localparam int PHYS_PINS    = 30;
    localparam int BUTTONS_MAX  = 128;
    localparam int MAP_REGS     = 4;
    localparam int LEDS_PER_MAP = 6;
    localparam int ENTRY_W      = 9;
    localparam int MAP_W        = LEDS_PER_MAP * ENTRY_W;
    localparam int BTN_IDX_W    = 7;
    localparam int BTN_HALF_W   = 64;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = MAP_W;

    localparam int CNT_W        = $clog2(PHYS_PINS + 1);
    localparam int ROW_IDX_W    = 5;
    localparam int LAST_W       = 6;
    localparam int POS_W        = 8;
    localparam int SIZE_W       = 2 * CNT_W;
    localparam int LP_W         = SIZE_W + 1;
    localparam int LED_IDX_W    = $clog2(MAP_LEDS);

    localparam logic [LAST_W-1:0] ROW_NONE = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_MASK,
        CFG_COLUMN_MASK,
        CFG_SINGLE_MASK,
        CFG_LED_MAP_A,
        CFG_LED_MAP_B,
        CFG_LED_MAP_C,
        CFG_LED_MAP_D
    } t_cfg_idx;

    typedef struct packed {
        logic [PHYS_PINS-1:0]           row_mask;
        logic [PHYS_PINS-1:0]           column_mask;
        logic [PHYS_PINS-1:0]           single_mask;
        logic [MAP_REGS-1:0][MAP_W-1:0] led_map;
    } t_cfg;

    typedef struct packed {
        logic [PHYS_PINS-1:0] pin_levels;
        logic [ROW_IDX_W-1:0] row_index;
        logic                 row_valid;
        logic [POS_W-1:0]     next_scan_pos;
        logic [LAST_W-1:0]    next_last_row;
    } t_scan_res;

    // led state at a scan position, off beyond the led count
    function automatic logic led_at(input logic [LP_W-1:0] p,
                                    input logic [MAP_LEDS-1:0] latch);
        logic r;
        r = 1'b0;
        if (p < LP_W'(LED_COUNT) && p < LP_W'(MAP_LEDS)) begin
            r = latch[p[LED_IDX_W-1:0]];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/lmsd_cfg_regs.sv
`timescale 1ns / 1ps
// lmsd_cfg_regs: configuration register file of the led matrix scan driver
// depends on lmsd_pkg

module lmsd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [lmsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lmsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output lmsd_pkg::t_cfg                 o_cfg
);
    import lmsd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROW_MASK:    r_cfg.row_mask    <= i_cfg_data[PHYS_PINS-1:0];
                CFG_COLUMN_MASK: r_cfg.column_mask <= i_cfg_data[PHYS_PINS-1:0];
                CFG_SINGLE_MASK: r_cfg.single_mask <= i_cfg_data[PHYS_PINS-1:0];
                CFG_LED_MAP_A:   r_cfg.led_map[0]  <= i_cfg_data[MAP_W-1:0];
                CFG_LED_MAP_B:   r_cfg.led_map[1]  <= i_cfg_data[MAP_W-1:0];
                CFG_LED_MAP_C:   r_cfg.led_map[2]  <= i_cfg_data[MAP_W-1:0];
                CFG_LED_MAP_D:   r_cfg.led_map[3]  <= i_cfg_data[MAP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/lmsd_led_update.sv
`timescale 1ns / 1ps
// lmsd_led_update: next led latch from the button vector and the led map
// depends on lmsd_pkg

module lmsd_led_update (
    input  lmsd_pkg::t_cfg                   i_cfg,
    input  logic [lmsd_pkg::BTN_HALF_W-1:0]  i_buttons_low,
    input  logic [lmsd_pkg::BTN_HALF_W-1:0]  i_buttons_high,
    input  logic [lmsd_pkg::MAP_LEDS-1:0]    i_latch,
    output logic [lmsd_pkg::MAP_LEDS-1:0]    o_latch
);
    import lmsd_pkg::*;

    logic [BUTTONS_MAX-1:0] buttons;
    assign buttons = {i_buttons_high, i_buttons_low};

    always_comb begin
        logic [ENTRY_W-1:0]   e;
        logic [BTN_IDX_W-1:0] b;
        logic                 bit_v;
        o_latch = i_latch;
        for (int i = 0; i < MAP_LEDS; i++) begin
            e = i_cfg.led_map[i / LEDS_PER_MAP][ENTRY_W * (i % LEDS_PER_MAP) +: ENTRY_W];
            b = e[BTN_IDX_W-1:0];
            bit_v = (32'(b) < BUTTON_COUNT) ? buttons[b] : 1'b0;
            if (i < LED_COUNT && e[ENTRY_W-1]) begin
                o_latch[i] = bit_v ^ e[BTN_IDX_W];
            end
        end
    end

endmodule

>>> hw/rtl/lmsd_scan.sv
`timescale 1ns / 1ps
// lmsd_scan: pin roles, row selection, column and single pin levels for one tick
// depends on lmsd_pkg

module lmsd_scan (
    input  lmsd_pkg::t_cfg                 i_cfg,
    input  logic [lmsd_pkg::MAP_LEDS-1:0]  i_latch,
    input  logic [lmsd_pkg::LAST_W-1:0]    i_last_row,
    input  logic [lmsd_pkg::POS_W-1:0]     i_scan_pos,
    output lmsd_pkg::t_scan_res            o_res
);
    import lmsd_pkg::*;

    logic [PHYS_PINS-1:0] pin_lim;
    logic [PHYS_PINS-1:0] rows;
    logic [PHYS_PINS-1:0] cols;
    logic [PHYS_PINS-1:0] singles;
    logic [PHYS_PINS-1:0] cand;
    logic [CNT_W-1:0]     nrows;
    logic [CNT_W-1:0]     ncols;
    logic [SIZE_W-1:0]    size;
    logic [ROW_IDX_W-1:0] max_row;
    logic [ROW_IDX_W-1:0] sel;
    logic                 have_row;
    logic [POS_W-1:0]     end_pos;

    always_comb begin
        for (int i = 0; i < PHYS_PINS; i++) begin
            pin_lim[i] = (i < PIN_COUNT);
        end
    end

    // row wins over column, column over single
    assign rows    = i_cfg.row_mask & pin_lim;
    assign cols    = i_cfg.column_mask & ~rows & pin_lim;
    assign singles = i_cfg.single_mask & ~rows & ~cols & pin_lim;

    assign nrows = CNT_W'($countones(rows));
    assign ncols = CNT_W'($countones(cols));
    assign size  = SIZE_W'(nrows) * SIZE_W'(ncols);

    always_comb begin
        max_row = '0;
        for (int i = 0; i < PHYS_PINS; i++) begin
            if (rows[i]) begin
                max_row = ROW_IDX_W'(i);
            end
        end
    end

    // lowest row above the last one, else the highest row
    always_comb begin
        for (int i = 0; i < PHYS_PINS; i++) begin
            cand[i] = rows[i] && (i_last_row == ROW_NONE || LAST_W'(i) > i_last_row
                                  || ROW_IDX_W'(i) == max_row);
        end
        sel = '0;
        for (int i = PHYS_PINS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                sel = ROW_IDX_W'(i);
            end
        end
    end

    assign have_row = |cand;
    assign end_pos  = i_scan_pos + POS_W'(ncols);

    always_comb begin
        logic [PHYS_PINS-1:0] low;
        logic [CNT_W-1:0]     rank_c;
        logic [CNT_W-1:0]     rank_s;
        logic [POS_W-1:0]     cpos;
        o_res.pin_levels = '0;
        for (int j = 0; j < PHYS_PINS; j++) begin
            low    = PHYS_PINS'((64'd1 << j) - 64'd1);
            rank_c = CNT_W'($countones(cols & low));
            rank_s = CNT_W'($countones(singles & low));
            cpos   = i_scan_pos + POS_W'(rank_c);
            if (rows[j]) begin
                o_res.pin_levels[j] = have_row && (sel == ROW_IDX_W'(j));
            end else if (cols[j]) begin
                o_res.pin_levels[j] = !(have_row && led_at(LP_W'(cpos), i_latch));
            end else if (singles[j]) begin
                o_res.pin_levels[j] = led_at(LP_W'(size) + LP_W'(rank_s), i_latch);
            end
        end
        o_res.row_index     = have_row ? sel : '0;
        o_res.row_valid     = have_row;
        o_res.next_scan_pos = i_scan_pos;
        o_res.next_last_row = i_last_row;
        if (have_row) begin
            o_res.next_scan_pos = (SIZE_W'(end_pos) >= size) ? '0 : end_pos;
            o_res.next_last_row = (sel == max_row) ? ROW_NONE : LAST_W'(sel);
        end
    end

endmodule

>>> hw/rtl/led_matrix_scan_driver_top.sv
`timescale 1ns / 1ps
// led_matrix_scan_driver_top: led matrix row scan with single led pins
// depends on lmsd_pkg, lmsd_cfg_regs, lmsd_led_update, lmsd_scan
//
// channel   direction  handshake                 payload
// cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
// in        in         i_in_valid / o_in_ready   i_buttons_low, i_buttons_high
// out       out        o_out_valid / i_out_ready o_pin_levels, o_row_index,
//                                                o_row_valid, o_led_states
//
// one tick per cycle sustained while the output is not stalled
// a tick passes the input register and then the result register around the scan logic
// the led latch, last row and scan position update when a tick moves to the result register
// a stalled result holds while one more tick waits in the input register
// synchronous reset clears the valid flags, led latch, scan position and config, the last row reads as none

module led_matrix_scan_driver_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lmsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lmsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [lmsd_pkg::BTN_HALF_W-1:0] i_buttons_low,
    input  logic [lmsd_pkg::BTN_HALF_W-1:0] i_buttons_high,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [lmsd_pkg::PHYS_PINS-1:0]  o_pin_levels,
    output logic [lmsd_pkg::ROW_IDX_W-1:0]  o_row_index,
    output logic                            o_row_valid,
    output logic [lmsd_pkg::MAP_LEDS-1:0]   o_led_states
);
    import lmsd_pkg::*;

    t_cfg                  cfg;
    t_scan_res             scan_res;
    logic [MAP_LEDS-1:0]   n_led_latch;

    logic                  r_in_valid;
    logic [BTN_HALF_W-1:0] r_buttons_low;
    logic [BTN_HALF_W-1:0] r_buttons_high;
    logic [MAP_LEDS-1:0]   r_led_latch;
    logic [LAST_W-1:0]     r_last_row;
    logic [POS_W-1:0]      r_scan_pos;
    logic                  r_out_valid;
    logic [PHYS_PINS-1:0]  r_pin_levels;
    logic [ROW_IDX_W-1:0]  r_row_index;
    logic                  r_row_valid;
    logic [MAP_LEDS-1:0]   r_led_states;

    logic                  advance;
    logic                  in_xfer;

    assign o_cfg_ready = 1'b1;

    lmsd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lmsd_led_update u_led_update (
        .i_cfg          (cfg),
        .i_buttons_low  (r_buttons_low),
        .i_buttons_high (r_buttons_high),
        .i_latch        (r_led_latch),
        .o_latch        (n_led_latch)
    );

    lmsd_scan u_scan (
        .i_cfg      (cfg),
        .i_latch    (n_led_latch),
        .i_last_row (r_last_row),
        .i_scan_pos (r_scan_pos),
        .o_res      (scan_res)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_led_latch <= '0;
            r_last_row  <= ROW_NONE;
            r_scan_pos  <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_led_latch <= n_led_latch;
                r_last_row  <= scan_res.next_last_row;
                r_scan_pos  <= scan_res.next_scan_pos;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_buttons_low  <= i_buttons_low;
            r_buttons_high <= i_buttons_high;
        end
        if (advance) begin
            r_pin_levels <= scan_res.pin_levels;
            r_row_index  <= scan_res.row_index;
            r_row_valid  <= scan_res.row_valid;
            r_led_states <= n_led_latch;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pin_levels = r_pin_levels;
    assign o_row_index  = r_row_index;
    assign o_row_valid  = r_row_valid;
    assign o_led_states = r_led_states;

endmodule

>>> hw/rtl/lmsd_checker.sv
`timescale 1ns / 1ps
// lmsd_checker: port level checks of the led matrix scan driver, bound to the top level
// depends on lmsd_pkg and led_matrix_scan_driver_top

module lmsd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [lmsd_pkg::PHYS_PINS-1:0]  o_pin_levels,
    input logic [lmsd_pkg::ROW_IDX_W-1:0]  o_row_index,
    input logic                            o_row_valid,
    input logic [lmsd_pkg::MAP_LEDS-1:0]   o_led_states
);
    import lmsd_pkg::*;

    // no result right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // no row driven means row index zero
    a_row_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_row_valid |-> o_row_index == '0)
        else $error("row index set without a driven row");

    // the driven row pin is high
    a_row_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_row_valid |-> ((o_pin_levels >> o_row_index) & 1) == 1)
        else $error("driven row pin is low");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pin_levels)
            && $stable(o_led_states) && $stable(o_row_index))
        else $error("stalled result changed");

    // an input transfer is followed by a valid result
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |-> ##2 o_out_valid)
        else $error("no result after an input transfer");

endmodule

bind led_matrix_scan_driver_top lmsd_checker u_lmsd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_pin_levels (o_pin_levels),
    .o_row_index  (o_row_index),
    .o_row_valid  (o_row_valid),
    .o_led_states (o_led_states)
);
